@@ rtl/cawc_pkg.sv @@
// cawc_pkg: shared types and constants of the window compositor
// item structs, queue entry, opcodes and register indexes; no dependencies
package cawc_pkg;

  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;

  localparam logic [12:0] WIN_LIMIT = 13'd4096;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] OP_COPY  = 2'd0;
  localparam logic [1:0] OP_BLEND = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_W  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_H  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_X     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_Y     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_W     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_H     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] src_c0;
    logic [7:0] src_c1;
    logic [7:0] src_c2;
    logic [7:0] src_alpha;
    logic [8:0] read_col;
    logic [8:0] read_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic [7:0] out_alpha;
  } out_item_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] c2;
    logic [7:0] c1;
    logic [7:0] c0;
  } px_t;

  typedef struct packed {
    logic [1:0]         op;
    logic               hit;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    px_t                pix;
  } op_t;

endpackage

@@ rtl/clipped_alpha_window_compositor.sv @@
// clipped_alpha_window_compositor: top level of the RGBA8 window compositor
// connects cawc_front, cawc_fifo and cawc_back; uses cawc_pkg
//
// Input channel in_valid/in_ready/in_data carries pixel, clear and read items.
// Output channel out_valid/out_ready/out_data carries one pixel per read item.
// cfg_we/cfg_index/cfg_wdata write the canvas and window registers, idle only.
// While in_ready is high the front accepts one item per cycle into a
// four-entry queue and advances the window raster; the back runs one queued
// operation at a time on a single-port frame store of MAX_HEIGHT x
// 2**clog2(MAX_WIDTH) words: opaque pixel written directly, blended pixel
// in three steps (read, multiply, write), read through the store read into
// the output register, clipped pixel never reaching the back, clear one store
// word per cycle (262144 words at the defaults). A read outside the canvas
// skips the store read and goes straight to the output register.
// After reset the same clearing sweep runs first and in_ready stays low
// until it ends. A stalled receiver holds the result in the output register;
// the back waits on its next read and the queue then fills and drops in_ready.
module clipped_alpha_window_compositor import cawc_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic init_busy, q_full, q_push, q_valid, q_pop;
  op_t  q_in, q_head;

  cawc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .init_busy (init_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  cawc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  cawc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/cawc_front.sv @@
// cawc_front: configuration registers, window raster, clipping and classification
// turns accepted items into queue entries; uses cawc_pkg
module cawc_front import cawc_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  init_busy,
  input  logic                  q_full,
  output logic                  q_push,
  output op_t                   q_data
);

  logic [9:0]         canvas_w_r, canvas_h_r;
  logic [12:0]        win_x_r, win_y_r, win_w_r, win_h_r;
  logic               has_alpha_r;
  logic [COORD_W-1:0] src_col_r, src_col_nxt, src_row_r, src_row_nxt;

  logic [9:0]  eff_cw, eff_ch;
  logic [12:0] eff_ww, eff_wh, col_inc, row_inc;
  logic [14:0] dx, dy;
  logic        px_hit, rd_hit, accept, restart;

  assign in_ready = !q_full && !init_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    eff_cw = ({3'b000, canvas_w_r} > 13'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : canvas_w_r;
    eff_ch = ({3'b000, canvas_h_r} > 13'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : canvas_h_r;
    eff_ww = (win_w_r == 13'd0) ? 13'd1 : ((win_w_r > WIN_LIMIT) ? WIN_LIMIT : win_w_r);
    eff_wh = (win_h_r == 13'd0) ? 13'd1 : ((win_h_r > WIN_LIMIT) ? WIN_LIMIT : win_h_r);
    col_inc = {1'b0, src_col_r} + 13'd1;
    row_inc = {1'b0, src_row_r} + 13'd1;
    dx = {{2{win_x_r[12]}}, win_x_r} + {3'b000, src_col_r};
    dy = {{2{win_y_r[12]}}, win_y_r} + {3'b000, src_row_r};
    px_hit = !dx[14] && !dy[14] && (dx[13:0] < {4'b0000, eff_cw})
             && (dy[13:0] < {4'b0000, eff_ch});
    rd_hit = ({1'b0, in_data.read_col} < eff_cw) && ({1'b0, in_data.read_row} < eff_ch);
  end

  assign restart = cfg_we && (cfg_index == REG_WIN_X || cfg_index == REG_WIN_Y ||
                              cfg_index == REG_WIN_W || cfg_index == REG_WIN_H ||
                              cfg_index == REG_HAS_ALPHA);

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    if (restart || (accept && in_data.kind == KIND_CLEAR)) begin
      src_col_nxt = '0;
      src_row_nxt = '0;
    end else if (accept && in_data.kind == KIND_PIXEL) begin
      if (col_inc >= eff_ww) begin
        src_col_nxt = '0;
        src_row_nxt = (row_inc >= eff_wh) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        src_col_nxt = col_inc[COORD_W-1:0];
      end
    end
  end

  always_comb begin
    q_push        = 1'b0;
    q_data.op     = OP_CLEAR;
    q_data.hit    = 1'b0;
    q_data.col    = dx[COORD_W-1:0];
    q_data.row    = dy[COORD_W-1:0];
    q_data.pix.c0 = in_data.src_c0;
    q_data.pix.c1 = in_data.src_c1;
    q_data.pix.c2 = in_data.src_c2;
    q_data.pix.alpha = has_alpha_r ? in_data.src_alpha : 8'hFF;
    case (in_data.kind)
      KIND_PIXEL: begin
        q_push     = accept && px_hit;
        q_data.op  = has_alpha_r ? OP_BLEND : OP_COPY;
        q_data.hit = 1'b1;
      end
      KIND_CLEAR: begin
        q_push    = accept;
        q_data.op = OP_CLEAR;
      end
      KIND_READ: begin
        q_push     = accept;
        q_data.op  = OP_READ;
        q_data.hit = rd_hit;
        q_data.col = {3'b000, in_data.read_col};
        q_data.row = {3'b000, in_data.read_row};
      end
      default: q_push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_w_r  <= 10'd512;
      canvas_h_r  <= 10'd512;
      win_x_r     <= '0;
      win_y_r     <= '0;
      win_w_r     <= 13'd1;
      win_h_r     <= 13'd1;
      has_alpha_r <= 1'b0;
      src_col_r   <= '0;
      src_row_r   <= '0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_CANVAS_W:  canvas_w_r  <= cfg_wdata[9:0];
          REG_CANVAS_H:  canvas_h_r  <= cfg_wdata[9:0];
          REG_WIN_X:     win_x_r     <= cfg_wdata;
          REG_WIN_Y:     win_y_r     <= cfg_wdata;
          REG_WIN_W:     win_w_r     <= cfg_wdata;
          REG_WIN_H:     win_h_r     <= cfg_wdata;
          REG_HAS_ALPHA: has_alpha_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/cawc_fifo.sv @@
// cawc_fifo: short queue of operations between front and back
// uses cawc_pkg for the entry type and depth
module cawc_fifo import cawc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output op_t  head
);

  op_t                slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign valid = (cnt_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

@@ rtl/cawc_back.sv @@
// cawc_back: frame store, blend datapath, clear sweep and output register
// executes queued operations one at a time; uses cawc_pkg
module cawc_back import cawc_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  op_t       q_data,
  output logic      q_pop,
  output logic      init_busy,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CB    = $clog2(MAX_WIDTH);
  localparam int RB    = $clog2(MAX_HEIGHT);
  localparam int AW    = CB + RB;
  localparam int DEPTH = MAX_HEIGHT * (1 << CB);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_BLEND_RD  = 3'd1;
  localparam logic [2:0] ST_BLEND_MUL = 3'd2;
  localparam logic [2:0] ST_READ_WAIT = 3'd3;
  localparam logic [2:0] ST_CLEAR     = 3'd4;

  logic [31:0] mem [DEPTH];

  logic [2:0]        state_r, state_nxt;
  op_t               cur_r;
  logic [AW-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic              init_r, init_nxt;
  px_t               rdata_r;
  logic [3:0][15:0]  prod_r;
  logic              out_valid_r;
  out_item_t         out_data_r, out_load_data;
  logic              out_load, out_free;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr, op_addr, cur_addr;
  px_t               mem_wdata, blend_px;
  logic [7:0]        inv_a;

  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
    return t[15:8];
  endfunction

  assign op_addr   = {q_data.row[RB-1:0], q_data.col[CB-1:0]};
  assign cur_addr  = {cur_r.row[RB-1:0], cur_r.col[CB-1:0]};
  assign out_free  = !out_valid_r || out_ready;
  assign init_busy = init_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign inv_a     = 8'd255 - cur_r.pix.alpha;

  always_comb begin
    blend_px.c0    = div255(prod_r[0]);
    blend_px.c1    = div255(prod_r[1]);
    blend_px.c2    = div255(prod_r[2]);
    blend_px.alpha = cur_r.pix.alpha + div255(prod_r[3]);
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    init_nxt      = init_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = op_addr;
    mem_wdata     = q_data.pix;
    out_load      = 1'b0;
    out_load_data = '0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_data.op)
            OP_COPY: begin
              q_pop  = 1'b1;
              mem_we = 1'b1;
            end
            OP_BLEND: begin
              q_pop     = 1'b1;
              mem_re    = 1'b1;
              state_nxt = ST_BLEND_RD;
            end
            OP_READ: begin
              if (q_data.hit) begin
                q_pop     = 1'b1;
                mem_re    = 1'b1;
                state_nxt = ST_READ_WAIT;
              end else if (out_free) begin
                q_pop    = 1'b1;
                out_load = 1'b1;
              end
            end
            OP_CLEAR: begin
              q_pop       = 1'b1;
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLEAR;
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_BLEND_RD: state_nxt = ST_BLEND_MUL;
      ST_BLEND_MUL: begin
        mem_we    = 1'b1;
        mem_addr  = cur_addr;
        mem_wdata = blend_px;
        state_nxt = ST_IDLE;
      end
      ST_READ_WAIT: begin
        if (out_free) begin
          out_load                = 1'b1;
          out_load_data.out_c0    = rdata_r.c0;
          out_load_data.out_c1    = rdata_r.c1;
          out_load_data.out_c2    = rdata_r.c2;
          out_load_data.out_alpha = rdata_r.alpha;
          state_nxt               = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
          init_nxt  = 1'b0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_data;
    end
    if (state_r == ST_BLEND_RD) begin
      prod_r[0] <= {8'b0, cur_r.pix.c0} * {8'b0, cur_r.pix.alpha}
                   + {8'b0, rdata_r.c0} * {8'b0, inv_a};
      prod_r[1] <= {8'b0, cur_r.pix.c1} * {8'b0, cur_r.pix.alpha}
                   + {8'b0, rdata_r.c1} * {8'b0, inv_a};
      prod_r[2] <= {8'b0, cur_r.pix.c2} * {8'b0, cur_r.pix.alpha}
                   + {8'b0, rdata_r.c2} * {8'b0, inv_a};
      prod_r[3] <= {8'b0, rdata_r.alpha} * {8'b0, inv_a};
    end
    if (out_load) begin
      out_data_r <= out_load_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      init_r    <= init_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/cawc_chk.sv @@
// cawc_chk: port-level checks of the window compositor over time
// bound to clipped_alpha_window_compositor; uses cawc_pkg
module cawc_chk import cawc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // result held while the receiver stalls
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped under stall");

  // no result straight out of reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // clearing sweep blocks input after reset
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during reset sweep");

  // no read was taken in reset, so none can be delivered as soon as reset lifts
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result without a read item");

endmodule

bind clipped_alpha_window_compositor cawc_chk u_cawc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ tb/clipped_alpha_window_compositor_tb.sv @@
// clipped_alpha_window_compositor_tb: self-checking testbench of the window compositor
// streams pixel, clear and read transfers, predicts the frame store, checks every read
// depends on cawc_pkg and clipped_alpha_window_compositor
module clipped_alpha_window_compositor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cawc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int MAX_W         = 512;
  localparam int MAX_H         = 512;
  localparam int WIN_MAX       = 4096;
  localparam int STORE_WORDS   = MAX_W * MAX_H;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 800000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 240;
  localparam int CLEAR_PHASE   = 3;

  localparam logic [1:0]           KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 3'd7;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  px_t                pixel_store [STORE_WORDS];
  int                 ras_col = 0;
  int                 ras_row = 0;
  logic [9:0]         canvas_w = 10'd512;
  logic [9:0]         canvas_h = 10'd512;
  logic signed [12:0] win_x = '0;
  logic signed [12:0] win_y = '0;
  logic [12:0]        win_w = 13'd1;
  logic [12:0]        win_h = 13'd1;
  logic               blend_on = 1'b0;

  out_item_t read_results_q [$];
  int        fail_count  = 0;
  int        burst_left  = 0;
  int        rx_hold_len = 0;
  int        idle_cycles = 0;

  clipped_alpha_window_compositor i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial foreach (pixel_store[i]) pixel_store[i] = '0;

  function automatic int clamp_canvas(input logic [9:0] v, input int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic int window_span(input logic [12:0] v);
    if (v == 13'd0) return 1;
    return (int'(v) > WIN_MAX) ? WIN_MAX : int'(v);
  endfunction

  function automatic logic [7:0] mix_channel(input int s, input int d, input int a);
    return 8'((s * a + d * (255 - a)) / 255);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic in_item_t make_pixel(input int c0, input int c1, input int c2,
                                          input int a);
    in_item_t it;
    it.kind      = KIND_PIXEL;
    it.src_c0    = 8'(c0);
    it.src_c1    = 8'(c1);
    it.src_c2    = 8'(c2);
    it.src_alpha = 8'(a);
    it.read_col  = 9'($urandom);
    it.read_row  = 9'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_read(input int col, input int row);
    in_item_t it;
    it.kind      = KIND_READ;
    it.src_c0    = 8'($urandom);
    it.src_c1    = 8'($urandom);
    it.src_c2    = 8'($urandom);
    it.src_alpha = 8'($urandom);
    it.read_col  = 9'(col);
    it.read_row  = 9'(row);
    return it;
  endfunction

  function automatic in_item_t make_other(input logic [1:0] kind);
    in_item_t    it;
    logic [63:0] bits;
    bits    = {$urandom, $urandom};
    it      = bits[$bits(in_item_t)-1:0];
    it.kind = kind;
    return it;
  endfunction

  function automatic in_item_t rand_pixel();
    int a;
    case ($urandom_range(0, 7))
      0: a = 0;
      1: a = 255;
      default: a = $urandom_range(0, 255);
    endcase
    return make_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 255), a);
  endfunction

  // read aimed at the area the current window paints
  function automatic in_item_t window_read();
    int span_c;
    int span_r;
    int col;
    int row;
    span_c = (window_span(win_w) > 32) ? 32 : window_span(win_w);
    span_r = (window_span(win_h) > 32) ? 32 : window_span(win_h);
    col = int'(win_x) + $urandom_range(0, span_c - 1);
    row = int'(win_y) + $urandom_range(0, span_r - 1);
    if (col < 0 || col > 511) col = $urandom_range(0, 511);
    if (row < 0 || row > 511) row = $urandom_range(0, 511);
    return make_read(col, row);
  endfunction

  function automatic logic [12:0] pick_canvas_size();
    int size;
    case ($urandom_range(0, 9))
      0: size = 1;
      1: size = MAX_W;
      2: size = $urandom_range(513, 1023);
      3: size = 0;
      default: size = $urandom_range(2, 64);
    endcase
    return {3'($urandom), 10'(size)};
  endfunction

  function automatic logic [12:0] pick_window_size();
    case ($urandom_range(0, 15))
      0: return 13'd0;
      1: return 13'($urandom_range(4096, 8191));
      default: return 13'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [12:0] pick_window_offset(input int extent);
    if ($urandom_range(0, 3) == 0) return 13'($urandom);
    return 13'($urandom_range(0, extent + 8) - 6);
  endfunction

  task automatic send_item(input in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (read_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_default_opaque();
    send_item(make_read(511, 511));
    send_item(make_pixel(255, 0, 255, 0));
    send_item(make_pixel(0, 255, 0, 17));
    send_item(make_read(0, 0));
    send_item(make_other(KIND_UNUSED));
    send_item(make_read(0, 0));
    drain_results();
  endtask

  task automatic test_blend_and_clip();
    write_reg(REG_CANVAS_W, 13'd16);
    write_reg(REG_CANVAS_H, 13'd8);
    write_reg(REG_WIN_X, 13'(-1));
    write_reg(REG_WIN_Y, 13'd6);
    write_reg(REG_WIN_W, 13'd3);
    write_reg(REG_WIN_H, 13'd2);
    write_reg(REG_HAS_ALPHA, 13'd1);
    send_item(make_pixel(200, 100, 50, 0));
    send_item(make_pixel(255, 255, 255, 128));
    send_item(make_pixel(10, 20, 30, 255));
    send_item(make_pixel(1, 1, 1, 1));
    send_item(make_pixel(0, 0, 0, 0));
    send_item(make_pixel(255, 0, 128, 200));
    // raster wrapped, second coat on the first visible column
    send_item(make_pixel(7, 7, 7, 7));
    send_item(make_pixel(0, 0, 0, 64));
    send_item(make_read(0, 6));
    send_item(make_read(1, 6));
    send_item(make_read(1, 7));
    send_item(make_read(16, 6));
    send_item(make_read(0, 8));
    drain_results();
  endtask

  task automatic test_clear_and_limits();
    send_item(make_other(KIND_CLEAR));
    send_item(make_read(1, 6));
    drain_results();
    write_reg(REG_WIN_X, 13'd0);
    write_reg(REG_WIN_Y, 13'd0);
    send_item(make_pixel(90, 180, 45, 220));
    send_item(make_read(0, 0));
    drain_results();
    write_reg(REG_CANVAS_W, 13'd0);
    send_item(make_pixel(9, 9, 9, 9));
    send_item(make_read(0, 0));
    drain_results();
    write_reg(REG_SPARE, 13'h1FFF);
    write_reg(REG_CANVAS_W, 13'd1023);
    write_reg(REG_CANVAS_H, 13'd1023);
    write_reg(REG_WIN_X, 13'd4095);
    write_reg(REG_WIN_Y, 13'h1000);
    write_reg(REG_WIN_W, 13'd0);
    write_reg(REG_WIN_H, 13'h1FFF);
    write_reg(REG_HAS_ALPHA, 13'd0);
    send_item(make_pixel(1, 2, 3, 4));
    send_item(make_read(0, 0));
    send_item(make_read(511, 511));
    drain_results();
  endtask

  task automatic test_output_stall();
    write_reg(REG_CANVAS_W, 13'd512);
    write_reg(REG_CANVAS_H, 13'd512);
    write_reg(REG_WIN_X, 13'd100);
    write_reg(REG_WIN_Y, 13'd200);
    write_reg(REG_WIN_W, 13'd8);
    write_reg(REG_WIN_H, 13'd4);
    write_reg(REG_HAS_ALPHA, 13'd1);
    rx_hold_len = 400;
    for (int i = 0; i < 48; i++) begin
      if (i % 2 == 0) send_item(rand_pixel());
      else send_item(window_read());
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    int pick;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      if (phase == 0) begin
        write_reg(REG_CANVAS_W, 13'd512);
        write_reg(REG_CANVAS_H, 13'd512);
      end else begin
        write_reg(REG_CANVAS_W, pick_canvas_size());
        write_reg(REG_CANVAS_H, pick_canvas_size());
      end
      write_reg(REG_WIN_X, pick_window_offset(clamp_canvas(canvas_w, MAX_W)));
      write_reg(REG_WIN_Y, pick_window_offset(clamp_canvas(canvas_h, MAX_H)));
      write_reg(REG_WIN_W, pick_window_size());
      write_reg(REG_WIN_H, pick_window_size());
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 13'($urandom));
      write_reg(REG_HAS_ALPHA, {12'($urandom), 1'($urandom_range(0, 1))});
      if (phase == CLEAR_PHASE) send_item(make_other(KIND_CLEAR));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) send_item(rand_pixel());
        else if (pick < 95) begin
          if ($urandom_range(0, 3) == 0)
            send_item(make_read($urandom_range(0, 511), $urandom_range(0, 511)));
          else
            send_item(window_read());
        end else send_item(make_other(KIND_UNUSED));
      end
      send_item(window_read());
      drain_results();
    end
  endtask

  always @(posedge clk) begin : frame_predictor
    out_item_t want;
    px_t       old_px;
    px_t       new_px;
    int        dx;
    int        dy;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (read_results_q.size() == 0) begin
        $error("read result %h with no read pending", out_data);
        fail_count++;
      end else begin
        want = read_results_q.pop_front();
        check_field("out_c0", want.out_c0, out_data.out_c0);
        check_field("out_c1", want.out_c1, out_data.out_c1);
        check_field("out_c2", want.out_c2, out_data.out_c2);
        check_field("out_alpha", want.out_alpha, out_data.out_alpha);
      end
    end
    if (rst_n === 1'b1 && cfg_we === 1'b1) begin
      case (cfg_index)
        REG_CANVAS_W: canvas_w = cfg_wdata[9:0];
        REG_CANVAS_H: canvas_h = cfg_wdata[9:0];
        REG_WIN_X: win_x = $signed(cfg_wdata);
        REG_WIN_Y: win_y = $signed(cfg_wdata);
        REG_WIN_W: win_w = cfg_wdata;
        REG_WIN_H: win_h = cfg_wdata;
        REG_HAS_ALPHA: blend_on = cfg_wdata[0];
        default: ;
      endcase
      if (cfg_index inside {REG_WIN_X, REG_WIN_Y, REG_WIN_W, REG_WIN_H, REG_HAS_ALPHA}) begin
        ras_col = 0;
        ras_row = 0;
      end
    end
    if (rst_n === 1'b1 && in_valid === 1'b1 && in_ready === 1'b1) begin
      case (in_data.kind)
        KIND_PIXEL: begin
          dx = int'(win_x) + ras_col;
          dy = int'(win_y) + ras_row;
          if (dx >= 0 && dy >= 0 && dx < clamp_canvas(canvas_w, MAX_W) &&
              dy < clamp_canvas(canvas_h, MAX_H)) begin
            old_px = pixel_store[dy * MAX_W + dx];
            if (blend_on) begin
              new_px.c0    = mix_channel(in_data.src_c0, old_px.c0, in_data.src_alpha);
              new_px.c1    = mix_channel(in_data.src_c1, old_px.c1, in_data.src_alpha);
              new_px.c2    = mix_channel(in_data.src_c2, old_px.c2, in_data.src_alpha);
              new_px.alpha = 8'(int'(in_data.src_alpha) +
                                int'(old_px.alpha) * (255 - int'(in_data.src_alpha)) / 255);
            end else begin
              new_px.c0    = in_data.src_c0;
              new_px.c1    = in_data.src_c1;
              new_px.c2    = in_data.src_c2;
              new_px.alpha = 8'hFF;
            end
            pixel_store[dy * MAX_W + dx] = new_px;
          end
          ras_col++;
          if (ras_col >= window_span(win_w)) begin
            ras_col = 0;
            ras_row++;
            if (ras_row >= window_span(win_h)) ras_row = 0;
          end
        end
        KIND_CLEAR: begin
          foreach (pixel_store[i]) pixel_store[i] = '0;
          ras_col = 0;
          ras_row = 0;
        end
        KIND_READ: begin
          if (int'(in_data.read_col) < clamp_canvas(canvas_w, MAX_W) &&
              int'(in_data.read_row) < clamp_canvas(canvas_h, MAX_H))
            old_px = pixel_store[int'(in_data.read_row) * MAX_W + int'(in_data.read_col)];
          else
            old_px = '0;
          want.out_c0    = old_px.c0;
          want.out_c1    = old_px.c1;
          want.out_c2    = old_px.c2;
          want.out_alpha = old_px.alpha;
          read_results_q.push_back(want);
        end
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : idle_watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("clipped_alpha_window_compositor verification failed");
      $finish;
    end
  end

  initial begin : result_sink
    int   run_left;
    int   stall_len;
    logic level;
    run_left = 0;
    level    = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        stall_len   = rx_hold_len;
        rx_hold_len = 0;
        out_ready <= 1'b0;
        repeat (stall_len - 1) @(posedge clk);
        run_left = 0;
        level    = 1'b0;
      end else begin
        if (run_left == 0) begin
          level = !level;
          if (level)
            run_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 20);
          else
            run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 16)
                                                    : $urandom_range(1, 3);
        end
        out_ready <= level;
        run_left--;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_default_opaque();
    test_blend_and_clip();
    test_clear_and_limits();
    test_output_stall();
    test_random_traffic();
    drain_results();
    if (fail_count == 0) $display("clipped_alpha_window_compositor verification clean");
    else $display("clipped_alpha_window_compositor verification failed");
    $finish;
  end

endmodule
